>>> hdl/dss_pkg.sv
`default_nettype none
package dss_pkg;

   typedef enum logic [1:0] {
      DIR_FWD   = 2'd0,
      DIR_BWD   = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_SET_FWD = 2'd1,
      CMD_SET_BWD = 2'd2,
      CMD_STOP    = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_DRIVE = 1'b0,
      KIND_STOP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MIN_FLIP_SPEED = 2'd0,
      CSR_MAX_SPEED      = 2'd1,
      CSR_SPEED_STEP     = 2'd2,
      CSR_START_SPEED    = 2'd3
   } csr_index_type;

   localparam logic [7:0] MIN_FLIP_SPEED_RESET = 8'd30;
   localparam logic [7:0] MAX_SPEED_RESET      = 8'd160;
   localparam logic [7:0] SPEED_STEP_RESET     = 8'd5;
   localparam logic [7:0] START_SPEED_RESET    = 8'd60;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      kind_type   kind;
      dir_type    request_dir;
      logic       bumper_left;
      logic       bumper_right;
      logic       movement_done;
      dir_type    dest_dir_left;
      dir_type    dest_dir_right;
   } req_item_type;

   typedef struct packed {
      cmd_type           dir_command;
      logic signed [8:0] left_speed;
      logic signed [8:0] right_speed;
   } rsp_item_type;

   typedef struct packed {
      logic signed [8:0] forward_speed;
      logic signed [8:0] turn_speed;
      logic              turning;
   } drive_state_type;

   typedef struct packed {
      logic [7:0] min_flip_speed;
      logic [7:0] max_speed;
      logic [7:0] speed_step;
      logic [7:0] start_speed;
   } cfg_type;

endpackage
`default_nettype wire

>>> hdl/drive_speed_stepper_core.sv
// channel   ports                         payload
// request   req_tvalid/tready/tdata/tuser drive request or stop
// response  rsp_tvalid/tready/tdata       direction command and wheel speeds
// csr       csr_valid/ready/index/data    speed settings, write only
//
// one request per cycle if unstalled: input register, step and mix logic, result register
// a request passes the input register, then the result register; blocked requests give nothing
// speed state is updated in the same cycle the request leaves the input register
// a stalled response holds the request in the input register; csr_ready is always high
// reset clears speeds and turning flag and loads the default settings
`default_nettype none
module drive_speed_stepper_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [1:0] request_dir, [2] bumper_left, [3] bumper_right, [4] movement_done,
   // [6:5] dest_dir_left, [8:7] dest_dir_right, [15:9] zero
   input  wire logic [dss_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] kind
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [1:0] dir_command, [10:2] left_speed, [19:11] right_speed, [23:20] zero
   output logic [dss_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [7:0]                        csr_data
);

   logic                      item_valid;
   dss_pkg::req_item_type     item;
   dss_pkg::drive_state_type  state_ff;
   dss_pkg::drive_state_type  state_in;
   dss_pkg::cfg_type          cfg_ff;
   dss_pkg::cfg_type          cfg_in;
   dss_pkg::rsp_item_type     result;
   logic                      has_result;
   logic                      can_load;
   logic                      take;

   assign take      = item_valid && (!has_result || can_load);
   assign csr_ready = 1'b1;

   dss_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dss_calc u_calc (
      .item       (item),
      .state_cur  (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .result     (result),
      .has_result (has_result)
   );

   dss_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take && has_result),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (dss_pkg::csr_index_type'(csr_index))
            dss_pkg::CSR_MIN_FLIP_SPEED: cfg_in.min_flip_speed = csr_data;
            dss_pkg::CSR_MAX_SPEED:      cfg_in.max_speed      = csr_data;
            dss_pkg::CSR_SPEED_STEP:     cfg_in.speed_step     = csr_data;
            dss_pkg::CSR_START_SPEED:    cfg_in.start_speed    = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.forward_speed <= 9'sd0;
         state_ff.turn_speed    <= 9'sd0;
         state_ff.turning       <= 1'b0;
         cfg_ff.min_flip_speed  <= dss_pkg::MIN_FLIP_SPEED_RESET;
         cfg_ff.max_speed       <= dss_pkg::MAX_SPEED_RESET;
         cfg_ff.speed_step      <= dss_pkg::SPEED_STEP_RESET;
         cfg_ff.start_speed     <= dss_pkg::START_SPEED_RESET;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         cfg_ff <= cfg_in;
      end
   end

`ifndef SYNTHESIS
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (take && item.kind == dss_pkg::KIND_STOP) |=>
      (state_ff.forward_speed == 9'sd0 && state_ff.turn_speed == 9'sd0 &&
       !state_ff.turning))
      else $error("stop did not clear speed state");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_tready)
      else $error("input register empty but request not taken");

   a_wheels_same_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
      !($signed(rsp_tdata[10:2]) < 0 && $signed(rsp_tdata[19:11]) > 0) &&
      !($signed(rsp_tdata[10:2]) > 0 && $signed(rsp_tdata[19:11]) < 0))
      else $error("wheel speeds of opposite sign");

   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      (take && !has_result) |=> $stable(state_ff))
      else $error("blocked request changed speed state");
`endif

endmodule
`default_nettype wire

>>> hdl/dss_in_reg.sv
`default_nettype none
module dss_in_reg (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [dss_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire logic                                  req_tuser,
   input  wire logic                                  take,
   output logic                                       item_valid,
   output dss_pkg::req_item_type                      item
);

   logic                  valid_ff;
   logic                  valid_in;
   dss_pkg::req_item_type item_ff;
   dss_pkg::req_item_type item_in;
   logic                  accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in.kind           = dss_pkg::kind_type'(req_tuser);
      item_in.request_dir    = dss_pkg::dir_type'(req_tdata[1:0]);
      item_in.bumper_left    = req_tdata[2];
      item_in.bumper_right   = req_tdata[3];
      item_in.movement_done  = req_tdata[4];
      item_in.dest_dir_left  = dss_pkg::dir_type'(req_tdata[6:5]);
      item_in.dest_dir_right = dss_pkg::dir_type'(req_tdata[8:7]);
      valid_in = accept || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

>>> hdl/dss_calc.sv
`default_nettype none
module dss_calc (
   input  wire dss_pkg::req_item_type    item,
   input  wire dss_pkg::drive_state_type state_cur,
   input  wire dss_pkg::cfg_type         cfg,
   output dss_pkg::drive_state_type      state_next,
   output dss_pkg::rsp_item_type         result,
   output logic                          has_result
);

   // step, dead band skip, clamp; a zero step follows the downward rule
   function automatic logic signed [8:0] step_speed(
      input logic signed [8:0] speed,
      input logic [7:0]        step,
      input logic              up,
      input logic [7:0]        minf,
      input logic [7:0]        maxs
   );
      logic signed [10:0] s;
      logic signed [10:0] d;
      logic signed [10:0] mn;
      logic signed [10:0] mx;
      logic               pos;
      pos = up && (step != 8'd0);
      mn  = $signed({3'b000, minf});
      mx  = $signed({3'b000, maxs});
      d   = up ? $signed({3'b000, step}) : -$signed({3'b000, step});
      s   = $signed({{2{speed[8]}}, speed}) + d;
      if (pos) begin
         if (s < 0 && -s < mn) begin
            s = -s;
         end else if (s > 0 && s < mn) begin
            s = mn;
         end
      end else begin
         if (s > 0 && s < mn) begin
            s = -s;
         end else if (s < 0 && -s < mn) begin
            s = -mn;
         end
      end
      if (s < -mx) begin
         s = -mx;
      end else if (s > mx) begin
         s = mx;
      end
      return s[8:0];
   endfunction

   logic signed [8:0] fwd0;
   logic signed [8:0] turn0;
   logic signed [8:0] fwd1;
   logic signed [8:0] turn1;
   logic              straight;
   logic              turn_now;
   logic              blocked;
   logic signed [8:0] fwd_neg;
   logic signed [8:0] turn_neg;
   logic [7:0]        mag;
   logic [7:0]        tmag;
   logic [7:0]        cut;
   logic [7:0]        left_mag;
   logic [7:0]        right_mag;
   dss_pkg::cmd_type  cmd;

   always_comb begin
      straight = (item.request_dir == dss_pkg::DIR_FWD) ||
                 (item.request_dir == dss_pkg::DIR_BWD);
      turn_now = !straight;
      blocked  = item.bumper_left || item.bumper_right || !item.movement_done;

      // standstill takes the start speed first
      if (state_cur.forward_speed == 9'sd0) begin
         fwd0 = (item.request_dir == dss_pkg::DIR_BWD) ?
                -$signed({1'b0, cfg.start_speed}) : $signed({1'b0, cfg.start_speed});
      end else begin
         fwd0 = state_cur.forward_speed;
      end
      turn0 = (straight && state_cur.turning) ? 9'sd0 : state_cur.turn_speed;

      fwd1  = fwd0;
      turn1 = turn0;
      unique case (item.request_dir)
         dss_pkg::DIR_FWD: fwd1 = step_speed(fwd0, cfg.speed_step, 1'b1,
                                             cfg.min_flip_speed, cfg.max_speed);
         dss_pkg::DIR_BWD: fwd1 = step_speed(fwd0, cfg.speed_step, 1'b0,
                                             cfg.min_flip_speed, cfg.max_speed);
         dss_pkg::DIR_RIGHT: turn1 = step_speed(turn0, cfg.speed_step, 1'b1,
                                                cfg.min_flip_speed, cfg.max_speed);
         dss_pkg::DIR_LEFT: turn1 = step_speed(turn0, cfg.speed_step, 1'b0,
                                               cfg.min_flip_speed, cfg.max_speed);
         default: fwd1 = fwd0;
      endcase

      if (fwd1 < 0) begin
         cmd = (item.dest_dir_left != dss_pkg::DIR_BWD ||
                item.dest_dir_right != dss_pkg::DIR_BWD) ?
               dss_pkg::CMD_SET_BWD : dss_pkg::CMD_NONE;
      end else begin
         cmd = (item.dest_dir_left != dss_pkg::DIR_FWD ||
                item.dest_dir_right != dss_pkg::DIR_FWD) ?
               dss_pkg::CMD_SET_FWD : dss_pkg::CMD_NONE;
      end

      // turn mixing slows the inner wheel by the turn magnitude
      fwd_neg  = -fwd1;
      turn_neg = -turn1;
      mag  = fwd1[8] ? fwd_neg[7:0] : fwd1[7:0];
      tmag = turn1[8] ? turn_neg[7:0] : turn1[7:0];
      cut  = (mag < tmag) ? mag : tmag;
      if (turn1[8]) begin
         left_mag  = mag - cut;
         right_mag = mag;
      end else begin
         left_mag  = mag;
         right_mag = mag - cut;
      end

      priority if (item.kind == dss_pkg::KIND_STOP) begin
         has_result                = 1'b1;
         state_next.forward_speed  = 9'sd0;
         state_next.turn_speed     = 9'sd0;
         state_next.turning        = 1'b0;
         result.dir_command        = dss_pkg::CMD_STOP;
         result.left_speed         = 9'sd0;
         result.right_speed        = 9'sd0;
      end else if (blocked) begin
         has_result                = 1'b0;
         state_next                = state_cur;
         result.dir_command        = dss_pkg::CMD_NONE;
         result.left_speed         = 9'sd0;
         result.right_speed        = 9'sd0;
      end else begin
         has_result                = 1'b1;
         state_next.forward_speed  = fwd1;
         state_next.turn_speed     = turn1;
         state_next.turning        = turn_now;
         result.dir_command        = cmd;
         if (turn_now) begin
            result.left_speed  = fwd1[8] ? -$signed({1'b0, left_mag})
                                         : $signed({1'b0, left_mag});
            result.right_speed = fwd1[8] ? -$signed({1'b0, right_mag})
                                         : $signed({1'b0, right_mag});
         end else begin
            result.left_speed  = fwd1;
            result.right_speed = fwd1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/dss_out_reg.sv
`default_nettype none
module dss_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load,
   input  wire dss_pkg::rsp_item_type             result,
   output logic                                   can_load,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dss_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic                  valid_ff;
   logic                  valid_in;
   dss_pkg::rsp_item_type result_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, result_ff.right_speed, result_ff.left_speed,
                        result_ff.dir_command};

endmodule
`default_nettype wire

>>> dv/wheel_speed_checker.sv
`timescale 1ns / 100ps
module wheel_speed_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [dss_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tuser,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [dss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [7:0]                     csr_data,
   output int unsigned                         outstanding,
   output int unsigned                         mismatch_total,
   output int unsigned                         responses_seen
);

   dss_pkg::cfg_type      settings;
   logic signed [8:0]     fwd_speed;
   logic signed [8:0]     yaw_speed;
   logic                  in_turn;
   dss_pkg::rsp_item_type wheel_speeds_due [$];
   int unsigned           mismatches = 0;
   int unsigned           checked = 0;

   // step, jump over the dead band around zero, then clamp
   function automatic logic signed [8:0] stepped_speed(input logic signed [8:0] speed,
                                                       input int delta);
      int s;
      int minf;
      int maxs;
      minf = settings.min_flip_speed;
      maxs = settings.max_speed;
      s = int'(speed) + delta;
      if (delta > 0) begin
         if (s < 0 && -s < minf) s = -s;
         else if (s > 0 && s < minf) s = minf;
      end else begin
         if (s > 0 && s < minf) s = -s;
         else if (s < 0 && -s < minf) s = -minf;
      end
      if (s < -maxs) s = -maxs;
      else if (s > maxs) s = maxs;
      return s[8:0];
   endfunction

   // updates the speed state; returns 1 when the request yields a response
   function automatic bit advance_drive(input dss_pkg::req_item_type r,
                                        output dss_pkg::rsp_item_type o);
      int st;
      int fwd;
      int trn;
      int mag;
      int lft;
      int rgt;
      o = '0;
      if (r.kind == dss_pkg::KIND_STOP) begin
         fwd_speed = '0;
         yaw_speed = '0;
         in_turn = 1'b0;
         o.dir_command = dss_pkg::CMD_STOP;
         return 1'b1;
      end
      if (r.bumper_left || r.bumper_right || !r.movement_done) return 1'b0;
      st = settings.start_speed;
      if (fwd_speed == 0) fwd_speed = (r.request_dir == dss_pkg::DIR_BWD) ? 9'(-st) : 9'(st);
      if ((r.request_dir == dss_pkg::DIR_FWD || r.request_dir == dss_pkg::DIR_BWD) && in_turn)
         yaw_speed = '0;
      case (r.request_dir)
         dss_pkg::DIR_FWD:
            fwd_speed = stepped_speed(fwd_speed, int'(settings.speed_step));
         dss_pkg::DIR_BWD:
            fwd_speed = stepped_speed(fwd_speed, -int'(settings.speed_step));
         dss_pkg::DIR_RIGHT:
            yaw_speed = stepped_speed(yaw_speed, int'(settings.speed_step));
         default:
            yaw_speed = stepped_speed(yaw_speed, -int'(settings.speed_step));
      endcase
      in_turn = (r.request_dir == dss_pkg::DIR_LEFT || r.request_dir == dss_pkg::DIR_RIGHT);
      fwd = fwd_speed;
      trn = yaw_speed;
      if (fwd < 0) begin
         o.dir_command = (r.dest_dir_left != dss_pkg::DIR_BWD ||
                          r.dest_dir_right != dss_pkg::DIR_BWD) ?
                         dss_pkg::CMD_SET_BWD : dss_pkg::CMD_NONE;
      end else begin
         o.dir_command = (r.dest_dir_left != dss_pkg::DIR_FWD ||
                          r.dest_dir_right != dss_pkg::DIR_FWD) ?
                         dss_pkg::CMD_SET_FWD : dss_pkg::CMD_NONE;
      end
      if (in_turn) begin
         // inner wheel slows by the turn speed, never below zero
         mag = (fwd < 0) ? -fwd : fwd;
         if (trn < 0) begin
            lft = mag - ((mag < -trn) ? mag : -trn);
            rgt = mag;
         end else begin
            lft = mag;
            rgt = mag - ((mag < trn) ? mag : trn);
         end
         if (fwd < 0) begin
            lft = -lft;
            rgt = -rgt;
         end
      end else begin
         lft = fwd;
         rgt = fwd;
      end
      o.left_speed = lft[8:0];
      o.right_speed = rgt[8:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      dss_pkg::req_item_type r;
      dss_pkg::rsp_item_type due;
      dss_pkg::rsp_item_type seen;
      if (reset) begin
         settings = '{dss_pkg::MIN_FLIP_SPEED_RESET, dss_pkg::MAX_SPEED_RESET,
                      dss_pkg::SPEED_STEP_RESET, dss_pkg::START_SPEED_RESET};
         fwd_speed = '0;
         yaw_speed = '0;
         in_turn = 1'b0;
         wheel_speeds_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (dss_pkg::csr_index_type'(csr_index))
               dss_pkg::CSR_MIN_FLIP_SPEED: settings.min_flip_speed = csr_data;
               dss_pkg::CSR_MAX_SPEED:      settings.max_speed = csr_data;
               dss_pkg::CSR_SPEED_STEP:     settings.speed_step = csr_data;
               default:                     settings.start_speed = csr_data;
            endcase
         end
         // a response here always belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            seen.dir_command = dss_pkg::cmd_type'(rsp_tdata[1:0]);
            seen.left_speed = rsp_tdata[10:2];
            seen.right_speed = rsp_tdata[19:11];
            checked++;
            if (wheel_speeds_due.size() == 0) begin
               $error("response with nothing outstanding: dir_command %0d left %0d right %0d",
                      seen.dir_command, seen.left_speed, seen.right_speed);
               mismatches++;
            end else begin
               due = wheel_speeds_due.pop_front();
               if (seen.dir_command != due.dir_command) begin
                  $error("dir_command: expected %0d, got %0d",
                         due.dir_command, seen.dir_command);
                  mismatches++;
               end
               if (seen.left_speed != due.left_speed) begin
                  $error("left_speed: expected %0d, got %0d",
                         due.left_speed, seen.left_speed);
                  mismatches++;
               end
               if (seen.right_speed != due.right_speed) begin
                  $error("right_speed: expected %0d, got %0d",
                         due.right_speed, seen.right_speed);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            r.kind = dss_pkg::kind_type'(req_tuser);
            r.request_dir = dss_pkg::dir_type'(req_tdata[1:0]);
            r.bumper_left = req_tdata[2];
            r.bumper_right = req_tdata[3];
            r.movement_done = req_tdata[4];
            r.dest_dir_left = dss_pkg::dir_type'(req_tdata[6:5]);
            r.dest_dir_right = dss_pkg::dir_type'(req_tdata[8:7]);
            if (advance_drive(r, due)) wheel_speeds_due.push_back(due);
         end
      end
      outstanding <= wheel_speeds_due.size();
      mismatch_total <= mismatches;
      responses_seen <= checked;
   end

endmodule

>>> dv/drive_speed_stepper_core_test.sv
`timescale 1ns / 100ps
module drive_speed_stepper_core_test;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // [1:0] request_dir, [2] bumper_left, [3] bumper_right, [4] movement_done,
   // [6:5] dest_dir_left, [8:7] dest_dir_right, [15:9] zero
   logic [dss_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // [0] kind
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // [1:0] dir_command, [10:2] left_speed, [19:11] right_speed, [23:20] zero
   logic [dss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [1:0]                     csr_index = '0;
   logic [7:0]                     csr_data = '0;

   int unsigned outstanding;
   int unsigned mismatch_total;
   int unsigned responses_seen;
   int unsigned send_idle_pct = 14;
   int unsigned take_idle_pct = 46;
   int unsigned long_stall_left = 0;
   bit          long_stall_request = 1'b0;
   int unsigned requests_sent = 0;
   int unsigned settings_applied = 0;

   drive_speed_stepper_core dut (.*);

   wheel_speed_checker wheel_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .mismatch_total (mismatch_total),
      .responses_seen (responses_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side back-pressure, with an occasional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            long_stall_left = 300;
         end
         if (long_stall_left > 0) begin
            long_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_request(input dss_pkg::req_item_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {7'd0, r.dest_dir_right, r.dest_dir_left, r.movement_done,
                    r.bumper_right, r.bumper_left, r.request_dir};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drive(input dss_pkg::dir_type d, input dss_pkg::dir_type dl,
                        input dss_pkg::dir_type dr);
      send_request('{dss_pkg::KIND_DRIVE, d, 1'b0, 1'b0, 1'b1, dl, dr});
   endtask

   // wait for every response, plus a margin for blocked requests still in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input dss_pkg::csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_settings(input dss_pkg::cfg_type s);
      write_register(dss_pkg::CSR_MIN_FLIP_SPEED, s.min_flip_speed);
      write_register(dss_pkg::CSR_MAX_SPEED, s.max_speed);
      write_register(dss_pkg::CSR_SPEED_STEP, s.speed_step);
      write_register(dss_pkg::CSR_START_SPEED, s.start_speed);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // bursts in one direction so speeds cross zero and reach the clamp
   task automatic run_random(input int unsigned target);
      int unsigned           made;
      int unsigned           burst;
      int unsigned           roll;
      dss_pkg::dir_type      d;
      dss_pkg::req_item_type r;
      made = 0;
      while (made < target) begin
         d = dss_pkg::dir_type'($urandom_range(3));
         burst = $urandom_range(1, 10);
         repeat (burst) begin
            r.kind = dss_pkg::KIND_DRIVE;
            r.request_dir = d;
            r.bumper_left = 1'b0;
            r.bumper_right = 1'b0;
            r.movement_done = 1'b1;
            r.dest_dir_left = dss_pkg::dir_type'($urandom_range(3));
            r.dest_dir_right = dss_pkg::dir_type'($urandom_range(3));
            if ($urandom_range(3) == 0) begin
               r.dest_dir_left = dss_pkg::dir_type'($urandom_range(1));
               r.dest_dir_right = r.dest_dir_left;
            end
            roll = $urandom_range(99);
            if (roll < 5) begin
               r.kind = dss_pkg::KIND_STOP;
               r.request_dir = dss_pkg::dir_type'($urandom_range(3));
               r.bumper_left = $urandom_range(1);
               r.bumper_right = $urandom_range(1);
               r.movement_done = $urandom_range(1);
            end else if (roll < 15) begin
               r.bumper_left = $urandom_range(1);
               r.bumper_right = $urandom_range(1);
               r.movement_done = $urandom_range(1);
               if (!r.bumper_left && !r.bumper_right) r.movement_done = 1'b0;
            end
            send_request(r);
            if (r.kind == dss_pkg::KIND_STOP ||
                (!r.bumper_left && !r.bumper_right && r.movement_done))
               made++;
         end
      end
   endtask

   initial begin
      dss_pkg::cfg_type corner_settings [5];
      dss_pkg::cfg_type s;
      corner_settings[0] = '{8'd0, 8'd255, 8'd255, 8'd255};
      // minimum above maximum, zero start speed
      corner_settings[1] = '{8'd255, 8'd1, 8'd1, 8'd0};
      // zero step, start speed above the clamp
      corner_settings[2] = '{8'd80, 8'd120, 8'd0, 8'd200};
      corner_settings[3] = '{8'd30, 8'd160, 8'd5, 8'd60};
      corner_settings[4] = '{8'd8, 8'd40, 8'd3, 8'd20};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // stop is taken even with bumpers pressed and movement unfinished
      send_request('{dss_pkg::KIND_STOP, dss_pkg::DIR_LEFT, 1'b1, 1'b1, 1'b0,
                     dss_pkg::DIR_RIGHT, dss_pkg::DIR_LEFT});
      send_request('{dss_pkg::KIND_DRIVE, dss_pkg::DIR_FWD, 1'b1, 1'b0, 1'b1,
                     dss_pkg::DIR_FWD, dss_pkg::DIR_FWD});
      send_request('{dss_pkg::KIND_DRIVE, dss_pkg::DIR_BWD, 1'b0, 1'b1, 1'b1,
                     dss_pkg::DIR_BWD, dss_pkg::DIR_BWD});
      send_request('{dss_pkg::KIND_DRIVE, dss_pkg::DIR_RIGHT, 1'b0, 1'b0, 1'b0,
                     dss_pkg::DIR_LEFT, dss_pkg::DIR_RIGHT});
      drive(dss_pkg::DIR_FWD, dss_pkg::DIR_FWD, dss_pkg::DIR_FWD);
      drive(dss_pkg::DIR_RIGHT, dss_pkg::DIR_LEFT, dss_pkg::DIR_RIGHT);
      drive(dss_pkg::DIR_LEFT, dss_pkg::DIR_FWD, dss_pkg::DIR_BWD);
      drive(dss_pkg::DIR_LEFT, dss_pkg::DIR_FWD, dss_pkg::DIR_FWD);
      drive(dss_pkg::DIR_FWD, dss_pkg::DIR_BWD, dss_pkg::DIR_FWD);
      send_request('{dss_pkg::KIND_STOP, dss_pkg::DIR_FWD, 1'b0, 1'b0, 1'b1,
                     dss_pkg::DIR_FWD, dss_pkg::DIR_FWD});
      drive(dss_pkg::DIR_BWD, dss_pkg::DIR_FWD, dss_pkg::DIR_FWD);
      drive(dss_pkg::DIR_BWD, dss_pkg::DIR_BWD, dss_pkg::DIR_BWD);
      drive(dss_pkg::DIR_RIGHT, dss_pkg::DIR_BWD, dss_pkg::DIR_BWD);
      drive(dss_pkg::DIR_FWD, dss_pkg::DIR_RIGHT, dss_pkg::DIR_LEFT);
      send_request('{dss_pkg::KIND_STOP, dss_pkg::DIR_RIGHT, 1'b0, 1'b1, 1'b0,
                     dss_pkg::DIR_BWD, dss_pkg::DIR_FWD});
      drive(dss_pkg::DIR_LEFT, dss_pkg::DIR_FWD, dss_pkg::DIR_FWD);

      for (int p = 0; p < 10; p++) begin
         if (p == 3) begin
            send_idle_pct = 46;
            take_idle_pct = 14;
         end else if (p == 6) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         settle();
         if (p < 5) begin
            s = corner_settings[p];
         end else begin
            s.min_flip_speed = $urandom_range(0, 80);
            s.max_speed = $urandom_range(1, 255);
            s.speed_step = $urandom_range(1, 30);
            s.start_speed = $urandom_range(0, 255);
         end
         apply_settings(s);
         if (p == 1 || p == 7) long_stall_request = 1'b1;
         run_random(185);
      end
      settle();

      $display("%0d requests driven across %0d speed settings, %0d responses checked",
               requests_sent, settings_applied, responses_seen);
      if (mismatch_total == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/dss_pkg.sv
hdl/dss_in_reg.sv
hdl/dss_calc.sv
hdl/dss_out_reg.sv
hdl/drive_speed_stepper_core.sv
dv/wheel_speed_checker.sv
dv/drive_speed_stepper_core_test.sv
